// ----- hw/rtl/qkl_pkg.sv -----
// Shared types, constants and constant table functions for the quadkey to lat/lon core.
package qkl_pkg;

  localparam int KEY_LEVELS_DEF = 24;
  localparam int KEY_W = 48;
  localparam int QUAD_W = 64;
  localparam int LAT_W = 32;
  localparam int LON_W = 33;
  localparam int MAG_W = 32;

  localparam int MUL_DEPTH = 3;
  localparam int HYP_STEPS = 53;
  localparam int CIRC_STEPS = 56;
  // mul, round, hyp, abs, mul, round, sum, circ, abs, mul, round
  localparam int LAT_DEPTH = MUL_DEPTH + 1 + HYP_STEPS + 1 + MUL_DEPTH + 1 + 1
                           + CIRC_STEPS + 1 + MUL_DEPTH + 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic signed [39:0] LON_OFFSET = 40'sd3019898880;

  typedef struct packed {
    logic [QUAD_W-1:0]       quad;
    logic signed [LON_W-1:0] lon;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
  } qkl_lane_t;

  typedef struct packed {
    qkl_lane_t first;
    qkl_lane_t second;
  } qkl_item_t;

  typedef struct packed {
    logic [QUAD_W-1:0]       first_quad;
    logic signed [LON_W-1:0] first_lon;
    logic [QUAD_W-1:0]       second_quad;
    logic signed [LON_W-1:0] second_lon;
  } qkl_side_t;

  // restoring division, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], n[k]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [63:0] series_q62(input int i, input logic alt);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int e;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      e = (2 * k + 1) * i;
      if (e <= 62) begin
        term = $signed(udiv(64'd1 << (62 - e), 64'(2 * k + 1)));
        if (alt && k[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] atanh_q62(input int i);
    if (i == 0) return '0;
    return series_q62(i, 1'b0);
  endfunction

  function automatic logic signed [63:0] atan_q62(input int i);
    if (i == 0) return $signed(PI_Q60);
    return series_q62(i, 1'b1);
  endfunction

  // shifts 1..50 with 4, 13 and 40 taken twice
  function automatic int hyp_shift(input int s);
    return s + 1 - ((s >= 4) ? 1 : 0) - ((s >= 14) ? 1 : 0) - ((s >= 42) ? 1 : 0);
  endfunction

  // 180/pi in Q56, rounded
  function automatic logic [63:0] deg_k();
    logic [63:0] r;
    logic [63:0] q;
    r = 64'd180;
    q = '0;
    for (int k = 0; k < 116; k++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= PI_Q60) begin
        r = r - PI_Q60;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= PI_Q60) q = q + 64'd1;
    return q;
  endfunction

endpackage

// ----- hw/rtl/qkl_mul.sv -----
// Pipelined 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
module qkl_mul (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [64:0]  mid_q;
  logic [127:0] base_q, p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q  <= a_i[31:0] * b_i[31:0];
      p01_q  <= a_i[31:0] * b_i[63:32];
      p10_q  <= a_i[63:32] * b_i[31:0];
      p11_q  <= a_i[63:32] * b_i[63:32];
      mid_q  <= {1'b0, p01_q} + {1'b0, p10_q};
      base_q <= {p11_q, p00_q};
      p_q    <= base_q + {31'b0, mid_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/qkl_lat.sv -----
// Latitude pipeline: hyperbolic CORDIC, doubling, circular vectoring, degree scaling.
module qkl_lat (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [qkl_pkg::MAG_W-1:0]        mag_i,
  input  logic                             neg_i,
  output logic signed [qkl_pkg::LAT_W-1:0] lat_o
);

  localparam int HS = qkl_pkg::HYP_STEPS;
  localparam int CS = qkl_pkg::CIRC_STEPS;
  localparam int LD = qkl_pkg::LAT_DEPTH;
  localparam logic signed [63:0] ONE_Q50 = 64'sd1 <<< 50;
  localparam logic [63:0] DEG_K = qkl_pkg::deg_k();

  logic [LD-2:0] neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) neg_q <= {neg_q[LD-3:0], neg_i};
  end

  // t/4 in Q62
  logic [127:0]       p1, p1r;
  logic signed [63:0] z0_q;

  qkl_mul u_mul_z (
    .clk_i,
    .en_i,
    .a_i (qkl_pkg::PI_Q60),
    .b_i ({32'b0, mag_i}),
    .p_o (p1)
  );

  assign p1r = p1 + (128'd1 << 30);

  always_ff @(posedge clk_i) begin
    if (en_i) z0_q <= $signed(p1r[94:31]);
  end

  // hyperbolic rotation
  logic signed [63:0] hx_q [HS];
  logic signed [63:0] hv_q [HS];
  logic signed [63:0] hz_q [HS];

  for (genvar s = 0; s < HS; s++) begin : g_hyp
    localparam int SH = qkl_pkg::hyp_shift(s);
    localparam logic signed [63:0] ANG = qkl_pkg::atanh_q62(SH);
    logic signed [63:0] x_in, v_in, z_in, dx, dy;
    if (s == 0) begin : g_in
      assign x_in = ONE_Q50;
      assign v_in = '0;
      assign z_in = z0_q;
    end else begin : g_in
      assign x_in = hx_q[s-1];
      assign v_in = hv_q[s-1];
      assign z_in = hz_q[s-1];
    end
    assign dx = v_in >>> SH;
    assign dy = x_in >>> SH;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[63]) begin
          hx_q[s] <= x_in + dx;
          hv_q[s] <= v_in + dy;
          hz_q[s] <= z_in - ANG;
        end else begin
          hx_q[s] <= x_in - dx;
          hv_q[s] <= v_in - dy;
          hz_q[s] <= z_in + ANG;
        end
      end
    end
  end

  // doubling products
  logic [63:0]  xa_q, va_q;
  logic         svx_q;
  logic [2:0]   sgd_q;
  logic [127:0] pxx, pvv, pvx, rxx, rvv, rvx;
  logic signed [63:0] c2a_q, c2b_q, s2i_q, c2_q, s2s_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xa_q  <= hx_q[HS-1][63] ? 64'd0 - $unsigned(hx_q[HS-1]) : $unsigned(hx_q[HS-1]);
      va_q  <= hv_q[HS-1][63] ? 64'd0 - $unsigned(hv_q[HS-1]) : $unsigned(hv_q[HS-1]);
      svx_q <= hx_q[HS-1][63] ^ hv_q[HS-1][63];
      sgd_q <= {sgd_q[1:0], svx_q};
    end
  end

  qkl_mul u_mul_xx (.clk_i, .en_i, .a_i(xa_q), .b_i(xa_q), .p_o(pxx));
  qkl_mul u_mul_vv (.clk_i, .en_i, .a_i(va_q), .b_i(va_q), .p_o(pvv));
  qkl_mul u_mul_vx (.clk_i, .en_i, .a_i(va_q), .b_i(xa_q), .p_o(pvx));

  assign rxx = pxx + (128'd1 << 43);
  assign rvv = pvv + (128'd1 << 43);
  assign rvx = pvx + (128'd1 << 42);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c2a_q <= $signed(rxx[107:44]);
      c2b_q <= $signed(rvv[107:44]);
      s2i_q <= sgd_q[2] ? -$signed(rvx[106:43]) : $signed(rvx[106:43]);
      c2_q  <= c2a_q + c2b_q;
      s2s_q <= s2i_q;
    end
  end

  // circular vectoring
  logic signed [63:0] cc_q [CS];
  logic signed [63:0] cs_q [CS];
  logic signed [63:0] ca_q [CS];

  for (genvar i = 0; i < CS; i++) begin : g_circ
    localparam logic signed [63:0] ANG = qkl_pkg::atan_q62(i);
    logic signed [63:0] c_in, s_in, a_in, dx, dy;
    if (i == 0) begin : g_in
      assign c_in = c2_q;
      assign s_in = s2s_q;
      assign a_in = '0;
    end else begin : g_in
      assign c_in = cc_q[i-1];
      assign s_in = cs_q[i-1];
      assign a_in = ca_q[i-1];
    end
    assign dx = s_in >>> i;
    assign dy = c_in >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!s_in[63]) begin
          cc_q[i] <= c_in + dx;
          cs_q[i] <= s_in - dy;
          ca_q[i] <= a_in + ANG;
        end else begin
          cc_q[i] <= c_in - dx;
          cs_q[i] <= s_in + dy;
          ca_q[i] <= a_in - ANG;
        end
      end
    end
  end

  // degree scaling
  logic [63:0]  a2, ua_q, r64, fin;
  logic         sa_q;
  logic [2:0]   sad_q;
  logic [127:0] p3, p3r;
  logic signed [qkl_pkg::LAT_W-1:0] lat_q;

  assign a2 = {ca_q[CS-1][62:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q  <= a2[63] ? 64'd0 - a2 : a2;
      sa_q  <= a2[63];
      sad_q <= {sad_q[1:0], sa_q};
    end
  end

  qkl_mul u_mul_deg (.clk_i, .en_i, .a_i(ua_q), .b_i(DEG_K), .p_o(p3));

  assign p3r = p3 + (128'd1 << 93);
  assign r64 = {30'b0, p3r[127:94]};
  assign fin = (sad_q[2] ^ neg_q[LD-2]) ? 64'd0 - r64 : r64;

  always_ff @(posedge clk_i) begin
    if (en_i) lat_q <= $signed(fin[qkl_pkg::LAT_W-1:0]);
  end

  assign lat_o = lat_q;

endmodule

// ----- hw/rtl/qkl_front.sv -----
// Front stage: takes a transaction, forms Morton codes, longitude and row magnitude.
module qkl_front #(
  parameter int KEY_LEVELS = qkl_pkg::KEY_LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [qkl_pkg::KEY_W-1:0]   first_key_i,
  input  logic [qkl_pkg::KEY_W-1:0]   second_key_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output qkl_pkg::qkl_item_t          push_data_o
);

  localparam int SHIFT = qkl_pkg::QUAD_W - 2 * KEY_LEVELS;

  function automatic qkl_pkg::qkl_lane_t decode(input logic [qkl_pkg::KEY_W-1:0] key);
    qkl_pkg::qkl_lane_t ln;
    logic [63:0] quad;
    logic [31:0] x, y;
    logic [38:0] prod;
    logic signed [39:0] lon;
    quad = {16'b0, key} << SHIFT;
    for (int b = 0; b < 32; b++) begin
      x[b] = quad[2*b];
      y[b] = quad[2*b+1];
    end
    prod = {7'b0, x} * 39'd45 + 39'd16;
    lon  = $signed({6'b0, prod[38:5]}) - qkl_pkg::LON_OFFSET;
    ln.quad = quad;
    ln.lon  = lon[qkl_pkg::LON_W-1:0];
    ln.neg  = y > 32'h8000_0000;
    ln.mag  = ln.neg ? y - 32'h8000_0000 : 32'h8000_0000 - y;
    return ln;
  endfunction

  logic               valid_q;
  qkl_pkg::qkl_item_t item_q;
  logic               adv;

  assign adv = !valid_q || push_ready_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      item_q.first  <= decode(first_key_i);
      item_q.second <= decode(second_key_i);
    end
  end

  assign push_valid_o = valid_q;
  assign push_data_o  = item_q;

endmodule

// ----- hw/rtl/qkl_fifo.sv -----
// Short register queue between the front stage and the latitude pipeline.
module qkl_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  qkl_pkg::qkl_item_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output qkl_pkg::qkl_item_t pop_data_o
);

  localparam int DEPTH = qkl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  qkl_pkg::qkl_item_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + PTR_W'(1);
      if (pop) rd_q <= rd_q + PTR_W'(1);
      if (push && !pop) cnt_q <= cnt_q + CNT_W'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ----- hw/rtl/quadkey_pair_to_latlon_core.sv -----
// Top level of the quadkey pair to Web Mercator latitude/longitude core.
//
// Input channel: in_valid_i / in_stall_o carry a transaction of two packed
// 48-bit quadkeys. Output channel: out_valid_o / out_stall_i carry both
// 64-bit Morton codes with each tile's latitude and longitude in degrees
// times 2^24 (two's complement). One result per input transaction, in order.
//
// Throughput: one transaction per cycle while the receiver does not stall.
// From acceptance, a transaction passes the front register, one queue slot
// and the 124-stage latitude pipeline (53 hyperbolic CORDIC stages, 56
// circular stages, three pipelined multiplies, and rounding, absolute-value
// and sum stages).
//
// When out_stall_i is high with a result shown, the whole back pipeline
// holds; the two-entry queue and the front register then fill and
// in_stall_o rises. Reset (rst_ni low, asynchronous) empties the queue and
// clears all valid flags; no result is shown until a new transaction ends.
module quadkey_pair_to_latlon_core #(
  parameter int KEY_LEVELS = qkl_pkg::KEY_LEVELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [qkl_pkg::KEY_W-1:0]        first_key_i,
  input  logic [qkl_pkg::KEY_W-1:0]        second_key_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [qkl_pkg::QUAD_W-1:0]       first_quad_o,
  output logic [qkl_pkg::QUAD_W-1:0]       second_quad_o,
  output logic signed [qkl_pkg::LAT_W-1:0] first_lat_o,
  output logic signed [qkl_pkg::LON_W-1:0] first_lon_o,
  output logic signed [qkl_pkg::LAT_W-1:0] second_lat_o,
  output logic signed [qkl_pkg::LON_W-1:0] second_lon_o
);

  localparam int LD = qkl_pkg::LAT_DEPTH;

  logic               push_valid, push_ready, head_valid, en;
  qkl_pkg::qkl_item_t push_data, head;

  qkl_front #(.KEY_LEVELS(KEY_LEVELS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .first_key_i,
    .second_key_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  qkl_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (head_valid),
    .pop_i        (en),
    .pop_data_o   (head)
  );

  assign en = !out_valid_o || !out_stall_i;

  logic [LD-1:0]      valid_q;
  qkl_pkg::qkl_side_t side_q [LD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LD-2:0], head_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].first_quad  <= head.first.quad;
      side_q[0].first_lon   <= head.first.lon;
      side_q[0].second_quad <= head.second.quad;
      side_q[0].second_lon  <= head.second.lon;
      for (int k = 1; k < LD; k++) side_q[k] <= side_q[k-1];
    end
  end

  qkl_lat u_lat_first (
    .clk_i,
    .en_i  (en),
    .mag_i (head.first.mag),
    .neg_i (head.first.neg),
    .lat_o (first_lat_o)
  );

  qkl_lat u_lat_second (
    .clk_i,
    .en_i  (en),
    .mag_i (head.second.mag),
    .neg_i (head.second.neg),
    .lat_o (second_lat_o)
  );

  assign out_valid_o   = valid_q[LD-1];
  assign first_quad_o  = side_q[LD-1].first_quad;
  assign first_lon_o   = side_q[LD-1].first_lon;
  assign second_quad_o = side_q[LD-1].second_quad;
  assign second_lon_o  = side_q[LD-1].second_lon;

endmodule

// ----- hw/rtl/qkl_checker.sv -----
// Port-level checks for the quadkey to lat/lon core, bound to the top level.
module qkl_checker #(
  parameter int KEY_LEVELS = qkl_pkg::KEY_LEVELS_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [qkl_pkg::QUAD_W-1:0]       first_quad_o,
  input logic [qkl_pkg::QUAD_W-1:0]       second_quad_o,
  input logic signed [qkl_pkg::LAT_W-1:0] first_lat_o,
  input logic signed [qkl_pkg::LON_W-1:0] first_lon_o,
  input logic signed [qkl_pkg::LAT_W-1:0] second_lat_o,
  input logic signed [qkl_pkg::LON_W-1:0] second_lon_o
);

  localparam int SHIFT = qkl_pkg::QUAD_W - 2 * KEY_LEVELS;
  localparam logic [63:0] LOW_MASK = (64'd1 << SHIFT) - 64'd1;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_lat_o)
      && $stable(second_lat_o) && $stable(first_quad_o) && $stable(second_quad_o))
    else $error("stalled result changed");

  a_quad_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((first_quad_o & LOW_MASK) == '0) && ((second_quad_o & LOW_MASK) == '0))
    else $error("Morton code has bits below the key");

  a_lon_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_lon_o >= -33'sd3019898880) && (first_lon_o <= 33'sd3019898879)
      && (second_lon_o >= -33'sd3019898880) && (second_lon_o <= 33'sd3019898879))
    else $error("longitude out of range");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

endmodule

bind quadkey_pair_to_latlon_core qkl_checker #(.KEY_LEVELS(KEY_LEVELS)) u_qkl_checker (.*);
